// ----- src/conv_rbm_hidden_sampler_unit_macros.svh -----
// ----------------------------------------------------------------------------
// conv_rbm_hidden_sampler_unit_macros.svh
// Assertion macros used by the hidden sampler top level.
// ----------------------------------------------------------------------------
`ifndef CONV_RBM_HIDDEN_SAMPLER_UNIT_MACROS_SVH
`define CONV_RBM_HIDDEN_SAMPLER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CRBM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CRBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/crbm_pkg.sv -----
// ----------------------------------------------------------------------------
// crbm_pkg
// Types, sizes, codes and the logistic table of the convolutional RBM sampler.
// ----------------------------------------------------------------------------
package crbm_pkg;

    // Sizing
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_FILTERS  = 8;
    localparam int MAX_KERNEL   = 8;
    localparam int MAX_IMAGE    = 32;

    localparam int VIS_DEPTH = MAX_CHANNELS * MAX_IMAGE * MAX_IMAGE;
    localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int VIS_AW    = $clog2(VIS_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);
    localparam int FLT_AW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int KIW       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CIW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Field widths
    localparam int DATA_W     = 16;
    localparam int PROB_W     = 16;
    localparam int CFG_CHAN_W = 3;
    localparam int CFG_KRN_W  = 4;
    localparam int CFG_IMG_W  = 6;
    localparam int CFG_FLT_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int CK_W       = CFG_CHAN_W + CFG_KRN_W;

    // Arithmetic: Q4.12 operands, Q.24 accumulator
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 42;
    localparam int BIAS_SHIFT = 12;
    localparam int HALF_BITS  = 23;
    localparam int SAT_BIT    = 27;
    localparam int SEG_W      = SAT_BIT - HALF_BITS;
    localparam int SLOPE_W    = DATA_W + HALF_BITS;

    // Item kinds
    localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_LOAD_BIAS   = 2'd1;
    localparam logic [1:0] KIND_LOAD_PIXEL  = 2'd2;
    localparam logic [1:0] KIND_COMPUTE     = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT  = 3'd5;

    typedef struct packed {
        logic [1:0]               kind;
        logic [11:0]              address;
        logic signed [DATA_W-1:0] value;
        logic [2:0]               filter;
        logic [4:0]               out_row;
        logic [4:0]               out_col;
        logic [15:0]              random_draw;
    } t_in_item;

    typedef struct packed {
        logic [PROB_W-1:0] probability;
        logic              sample;
        logic              status;
    } t_out_item;

    // Clamped register values as the datapath uses them
    typedef struct packed {
        logic [CFG_CHAN_W-1:0] chan;
        logic [CFG_KRN_W-1:0]  krow;
        logic [CFG_KRN_W-1:0]  kcol;
        logic [CFG_IMG_W-1:0]  irow;
        logic [CFG_IMG_W-1:0]  icol;
        logic [CFG_FLT_W-1:0]  filt;
    } t_cfg;

    // Sequencer strobes
    typedef struct packed {
        logic busy;
        logic bias_re;
        logic clear;
        logic rd_en;
    } t_seq_ctl;

    // Tag that travels with one memory read beat
    typedef struct packed {
        logic valid;
        logic last;
    } t_tap;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP0,
        ST_SETUP1,
        ST_SETUP2,
        ST_RUN,
        ST_FINISH
    } t_seq_state;

    // sigmoid(k/2) * 65536, rounded, k = 0..16
    function automatic logic [PROB_W-1:0] sig_tab(input logic [SEG_W:0] k);
        logic [PROB_W-1:0] v;
        case (k)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage

// ----- src/crbm_ram.sv -----
// ----------------------------------------------------------------------------
// crbm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/crbm_seq.sv -----
// ----------------------------------------------------------------------------
// crbm_seq
// Sequencer: sets up a compute item and walks the kernel volume, issuing one
// visible and one weight read per cycle.
// ----------------------------------------------------------------------------
module crbm_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  crbm_pkg::t_in_item          i_item,
    input  crbm_pkg::t_cfg              i_cfg,
    input  logic                        i_lgc_valid,
    output crbm_pkg::t_seq_ctl          o_ctl,
    output crbm_pkg::t_tap              o_tap,
    output logic [crbm_pkg::VIS_AW-1:0] o_vis_addr,
    output logic [crbm_pkg::WGT_AW-1:0] o_wgt_addr,
    output logic [crbm_pkg::FLT_AW-1:0] o_flt,
    output logic [15:0]                 o_draw
);

    crbm_pkg::t_seq_state r_state, n_state;
    crbm_pkg::t_tap       r_tap, n_tap;

    logic [2:0]                  r_filter;
    logic [4:0]                  r_orow;
    logic [4:0]                  r_ocol;
    logic [15:0]                 r_draw;
    logic [crbm_pkg::VIS_AW-1:0] r_plane;
    logic [crbm_pkg::CK_W-1:0]   r_ck;
    logic [crbm_pkg::VIS_AW-1:0] r_vbase;
    logic [crbm_pkg::WGT_AW-1:0] r_vol;
    logic [crbm_pkg::WGT_AW-1:0] r_wptr;
    logic [crbm_pkg::VIS_AW-1:0] r_vptr;
    logic [crbm_pkg::VIS_AW-1:0] r_vrow;
    logic [crbm_pkg::VIS_AW-1:0] r_vplane;
    logic [crbm_pkg::KIW-1:0]    r_j;
    logic [crbm_pkg::KIW-1:0]    r_i;
    logic [crbm_pkg::CIW-1:0]    r_ch;

    logic                        w_j_end;
    logic                        w_i_end;
    logic                        w_c_end;
    logic                        w_last;
    logic [crbm_pkg::VIS_AW-1:0] w_ic;
    logic [crbm_pkg::VIS_AW-1:0] w_next_row;
    logic [crbm_pkg::VIS_AW-1:0] w_next_plane;

    // Loop ends of the kernel walk
    assign w_j_end = (crbm_pkg::CFG_KRN_W'(r_j) + crbm_pkg::CFG_KRN_W'(1)) == i_cfg.kcol;
    assign w_i_end = (crbm_pkg::CFG_KRN_W'(r_i) + crbm_pkg::CFG_KRN_W'(1)) == i_cfg.krow;
    assign w_c_end = (crbm_pkg::CFG_CHAN_W'(r_ch) + crbm_pkg::CFG_CHAN_W'(1)) == i_cfg.chan;
    assign w_last  = w_j_end && w_i_end && w_c_end;

    assign w_ic         = crbm_pkg::VIS_AW'(i_cfg.icol);
    assign w_next_row   = r_vrow + w_ic;
    assign w_next_plane = r_vplane + r_plane;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            crbm_pkg::ST_IDLE:   if (i_go) n_state = crbm_pkg::ST_SETUP0;
            crbm_pkg::ST_SETUP0: n_state = crbm_pkg::ST_SETUP1;
            crbm_pkg::ST_SETUP1: n_state = crbm_pkg::ST_SETUP2;
            crbm_pkg::ST_SETUP2: n_state = crbm_pkg::ST_RUN;
            crbm_pkg::ST_RUN:    if (w_last) n_state = crbm_pkg::ST_FINISH;
            crbm_pkg::ST_FINISH: if (i_lgc_valid) n_state = crbm_pkg::ST_IDLE;
            default:             n_state = crbm_pkg::ST_IDLE;
        endcase
    end

    // Outputs per state
    always_comb begin
        o_ctl         = '0;
        o_ctl.busy    = (r_state != crbm_pkg::ST_IDLE);
        o_ctl.bias_re = (r_state == crbm_pkg::ST_SETUP0);
        o_ctl.clear   = (r_state == crbm_pkg::ST_SETUP1);
        o_ctl.rd_en   = (r_state == crbm_pkg::ST_RUN);
        n_tap.valid   = (r_state == crbm_pkg::ST_RUN);
        n_tap.last    = (r_state == crbm_pkg::ST_RUN) && w_last;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crbm_pkg::ST_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    // Setup products and address walk
    always_ff @(posedge i_clk) begin
        case (r_state)
            crbm_pkg::ST_IDLE: begin
                if (i_go) begin
                    r_filter <= i_item.filter;
                    r_orow   <= i_item.out_row;
                    r_ocol   <= i_item.out_col;
                    r_draw   <= i_item.random_draw;
                end
            end
            crbm_pkg::ST_SETUP0: begin
                r_plane <= crbm_pkg::VIS_AW'(i_cfg.irow) * w_ic;
                r_ck    <= crbm_pkg::CK_W'(i_cfg.chan) * crbm_pkg::CK_W'(i_cfg.krow);
                r_vbase <= crbm_pkg::VIS_AW'(r_orow) * w_ic + crbm_pkg::VIS_AW'(r_ocol);
            end
            crbm_pkg::ST_SETUP1: begin
                r_vol <= crbm_pkg::WGT_AW'(r_ck) * crbm_pkg::WGT_AW'(i_cfg.kcol);
            end
            crbm_pkg::ST_SETUP2: begin
                r_wptr   <= crbm_pkg::WGT_AW'(r_filter) * r_vol;
                r_vptr   <= r_vbase;
                r_vrow   <= r_vbase;
                r_vplane <= r_vbase;
                r_j      <= '0;
                r_i      <= '0;
                r_ch     <= '0;
            end
            crbm_pkg::ST_RUN: begin
                r_wptr <= r_wptr + crbm_pkg::WGT_AW'(1);
                if (!w_j_end) begin
                    r_j    <= r_j + crbm_pkg::KIW'(1);
                    r_vptr <= r_vptr + crbm_pkg::VIS_AW'(1);
                end else begin
                    r_j <= '0;
                    if (!w_i_end) begin
                        // advance to the next kernel row
                        r_i    <= r_i + crbm_pkg::KIW'(1);
                        r_vrow <= w_next_row;
                        r_vptr <= w_next_row;
                    end else begin
                        // advance to the next channel plane
                        r_i      <= '0;
                        r_ch     <= r_ch + crbm_pkg::CIW'(1);
                        r_vplane <= w_next_plane;
                        r_vrow   <= w_next_plane;
                        r_vptr   <= w_next_plane;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_tap      = r_tap;
    assign o_vis_addr = r_vptr;
    assign o_wgt_addr = r_wptr;
    assign o_flt      = crbm_pkg::FLT_AW'(r_filter);
    assign o_draw     = r_draw;

endmodule

// ----- src/crbm_mac.sv -----
// ----------------------------------------------------------------------------
// crbm_mac
// Multiply-accumulate: registered product, then a Q.24 accumulator that
// starts from the scaled hidden bias.
// ----------------------------------------------------------------------------
module crbm_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic [crbm_pkg::DATA_W-1:0] i_bias,
    input  crbm_pkg::t_tap              i_tap,
    input  logic [crbm_pkg::DATA_W-1:0] i_vis,
    input  logic [crbm_pkg::DATA_W-1:0] i_wgt,
    output logic                        o_done,
    output logic [crbm_pkg::ACC_W-1:0]  o_acc
);

    logic signed [crbm_pkg::PROD_W-1:0] r_prod;
    crbm_pkg::t_tap                     r_ptap;
    logic [crbm_pkg::ACC_W-1:0]         r_acc;
    logic                               r_done;

    logic [crbm_pkg::ACC_W-1:0] w_bias_sc;
    logic [crbm_pkg::ACC_W-1:0] w_prod_ext;

    // Bias in Q.24, product sign-extended to accumulator width
    assign w_bias_sc = {{(crbm_pkg::ACC_W - crbm_pkg::DATA_W - crbm_pkg::BIAS_SHIFT)
                         {i_bias[crbm_pkg::DATA_W-1]}},
                        i_bias, {crbm_pkg::BIAS_SHIFT{1'b0}}};
    assign w_prod_ext = {{(crbm_pkg::ACC_W - crbm_pkg::PROD_W){r_prod[crbm_pkg::PROD_W-1]}},
                         r_prod};

    // Product stage
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_vis) * $signed(i_wgt);
    end

    // Accumulate
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= w_bias_sc;
        end else if (r_ptap.valid) begin
            r_acc <= r_acc + w_prod_ext;
        end
    end

    // Tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptap <= '0;
            r_done <= 1'b0;
        end else begin
            r_ptap <= i_tap;
            r_done <= r_ptap.valid && r_ptap.last;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ----- src/crbm_logistic.sv -----
// ----------------------------------------------------------------------------
// crbm_logistic
// Three-stage piecewise-linear logistic on a Q.24 value, then the Bernoulli
// compare against the random draw.
// ----------------------------------------------------------------------------
module crbm_logistic (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [crbm_pkg::ACC_W-1:0] i_acc,
    input  logic [15:0]                i_draw,
    output logic                       o_valid,
    output crbm_pkg::t_out_item        o_result
);

    logic                           r_a_v;
    logic                           r_a_neg;
    logic                           r_a_sat;
    logic [crbm_pkg::SEG_W-1:0]     r_a_k;
    logic [crbm_pkg::HALF_BITS-1:0] r_a_t;

    logic                           r_b_v;
    logic                           r_b_neg;
    logic [crbm_pkg::PROB_W-1:0]    r_b_base;
    logic [crbm_pkg::SLOPE_W-1:0]   r_b_slope;

    logic                           r_c_v;
    crbm_pkg::t_out_item            r_c_res;

    logic [crbm_pkg::ACC_W-1:0]  w_mag;
    logic [crbm_pkg::SEG_W:0]    w_k0;
    logic [crbm_pkg::SEG_W:0]    w_k1;
    logic [crbm_pkg::PROB_W-1:0] w_lo;
    logic [crbm_pkg::PROB_W-1:0] w_hi;
    logic [crbm_pkg::PROB_W:0]   w_pos;
    logic [crbm_pkg::PROB_W:0]   w_p;

    // Stage A: magnitude and segment
    assign w_mag = i_acc[crbm_pkg::ACC_W-1] ? (crbm_pkg::ACC_W'(0) - i_acc) : i_acc;

    always_ff @(posedge i_clk) begin
        r_a_neg <= i_acc[crbm_pkg::ACC_W-1];
        r_a_sat <= |w_mag[crbm_pkg::ACC_W-1:crbm_pkg::SAT_BIT];
        r_a_k   <= w_mag[crbm_pkg::SAT_BIT-1:crbm_pkg::HALF_BITS];
        r_a_t   <= w_mag[crbm_pkg::HALF_BITS-1:0];
    end

    // Stage B: table lookup and slope product
    assign w_k0 = {1'b0, r_a_k};
    assign w_k1 = w_k0 + (crbm_pkg::SEG_W + 1)'(1);
    assign w_lo = crbm_pkg::sig_tab(w_k0);
    assign w_hi = crbm_pkg::sig_tab(w_k1);

    always_ff @(posedge i_clk) begin
        r_b_neg <= r_a_neg;
        if (r_a_sat) begin
            r_b_base  <= crbm_pkg::sig_tab({1'b1, {crbm_pkg::SEG_W{1'b0}}});
            r_b_slope <= '0;
        end else begin
            r_b_base  <= w_lo;
            r_b_slope <= crbm_pkg::SLOPE_W'(w_hi - w_lo) * crbm_pkg::SLOPE_W'(r_a_t);
        end
    end

    // Stage C: interpolate, mirror for negative input, draw the sample
    assign w_pos = (crbm_pkg::PROB_W + 1)'(r_b_base)
                 + (crbm_pkg::PROB_W + 1)'(r_b_slope[crbm_pkg::SLOPE_W-1:crbm_pkg::HALF_BITS]);
    assign w_p   = r_b_neg ? ({1'b1, {crbm_pkg::PROB_W{1'b0}}} - w_pos) : w_pos;

    always_ff @(posedge i_clk) begin
        r_c_res.probability <= w_p[crbm_pkg::PROB_W-1:0];
        r_c_res.sample      <= ({1'b0, i_draw} <= w_p);
        r_c_res.status      <= 1'b0;
    end

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    assign o_valid  = r_c_v;
    assign o_result = r_c_res;

endmodule

// ----- src/conv_rbm_hidden_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// conv_rbm_hidden_sampler_unit
// Convolutional RBM hidden-unit sampler: stores, sequencer, MAC and logistic.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Load beats (weight,
// bias, pixel) write one memory entry; busy stays low. A compute beat with a
// valid position and filter holds busy high through three setup states, the
// kernel walk, which reads one tap at a time through the single read port of
// the visible and weight memories feeding one multiplier, and then the read,
// MAC and logistic stages. Its result beat appears on o_valid in the cycle
// busy drops, and a new beat may be taken in that same cycle. A compute beat
// with a bad position or filter gives a status-1 result in the next cycle and
// leaves busy low. Results cannot be held off: o_valid is high for exactly
// one cycle per result. Stores are not cleared at reset; reading an unwritten
// entry gives undefined data. Write registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "conv_rbm_hidden_sampler_unit_macros.svh"

module conv_rbm_hidden_sampler_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  crbm_pkg::t_in_item               i_item,
    input  logic                             i_cfg_we,
    input  logic [crbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [crbm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_valid,
    output crbm_pkg::t_out_item              o_result
);

    // Configuration registers
    logic [crbm_pkg::CFG_CHAN_W-1:0] r_chan;
    logic [crbm_pkg::CFG_KRN_W-1:0]  r_krow;
    logic [crbm_pkg::CFG_KRN_W-1:0]  r_kcol;
    logic [crbm_pkg::CFG_IMG_W-1:0]  r_irow;
    logic [crbm_pkg::CFG_IMG_W-1:0]  r_icol;
    logic [crbm_pkg::CFG_FLT_W-1:0]  r_filt;

    crbm_pkg::t_cfg      w_cfg;
    crbm_pkg::t_seq_ctl  w_ctl;
    crbm_pkg::t_tap      w_tap;
    crbm_pkg::t_out_item w_lgc_res;
    crbm_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic                         w_take;
    logic                         w_cmp;
    logic                         w_bad;
    logic                         w_go;
    logic                         w_err_go;
    logic                         w_we_wgt;
    logic                         w_we_bias;
    logic                         w_we_vis;
    logic [crbm_pkg::VIS_AW-1:0]  w_vis_addr;
    logic [crbm_pkg::WGT_AW-1:0]  w_wgt_addr;
    logic [crbm_pkg::FLT_AW-1:0]  w_flt;
    logic [15:0]                  w_draw;
    logic [crbm_pkg::DATA_W-1:0]  w_vis_q;
    logic [crbm_pkg::DATA_W-1:0]  w_wgt_q;
    logic [crbm_pkg::DATA_W-1:0]  w_bias_q;
    logic                         w_mac_done;
    logic [crbm_pkg::ACC_W-1:0]   w_acc;
    logic                         w_lgc_valid;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= crbm_pkg::CFG_CHAN_W'(1);
            r_krow <= crbm_pkg::CFG_KRN_W'(1);
            r_kcol <= crbm_pkg::CFG_KRN_W'(1);
            r_irow <= crbm_pkg::CFG_IMG_W'(32);
            r_icol <= crbm_pkg::CFG_IMG_W'(32);
            r_filt <= crbm_pkg::CFG_FLT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crbm_pkg::CFG_CHANNEL_COUNT: r_chan <= i_cfg_data[crbm_pkg::CFG_CHAN_W-1:0];
                crbm_pkg::CFG_KERNEL_ROWS:   r_krow <= i_cfg_data[crbm_pkg::CFG_KRN_W-1:0];
                crbm_pkg::CFG_KERNEL_COLS:   r_kcol <= i_cfg_data[crbm_pkg::CFG_KRN_W-1:0];
                crbm_pkg::CFG_IMAGE_ROWS:    r_irow <= i_cfg_data[crbm_pkg::CFG_IMG_W-1:0];
                crbm_pkg::CFG_IMAGE_COLS:    r_icol <= i_cfg_data[crbm_pkg::CFG_IMG_W-1:0];
                crbm_pkg::CFG_FILTER_COUNT:  r_filt <= i_cfg_data[crbm_pkg::CFG_FLT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp registers: zero reads as one, above the maximum reads as the maximum
    always_comb begin
        w_cfg.chan = (r_chan == '0) ? crbm_pkg::CFG_CHAN_W'(1) :
                     (32'(r_chan) > crbm_pkg::MAX_CHANNELS) ?
                     crbm_pkg::CFG_CHAN_W'(crbm_pkg::MAX_CHANNELS) : r_chan;
        w_cfg.krow = (r_krow == '0) ? crbm_pkg::CFG_KRN_W'(1) :
                     (32'(r_krow) > crbm_pkg::MAX_KERNEL) ?
                     crbm_pkg::CFG_KRN_W'(crbm_pkg::MAX_KERNEL) : r_krow;
        w_cfg.kcol = (r_kcol == '0) ? crbm_pkg::CFG_KRN_W'(1) :
                     (32'(r_kcol) > crbm_pkg::MAX_KERNEL) ?
                     crbm_pkg::CFG_KRN_W'(crbm_pkg::MAX_KERNEL) : r_kcol;
        w_cfg.irow = (r_irow == '0) ? crbm_pkg::CFG_IMG_W'(1) :
                     (32'(r_irow) > crbm_pkg::MAX_IMAGE) ?
                     crbm_pkg::CFG_IMG_W'(crbm_pkg::MAX_IMAGE) : r_irow;
        w_cfg.icol = (r_icol == '0) ? crbm_pkg::CFG_IMG_W'(1) :
                     (32'(r_icol) > crbm_pkg::MAX_IMAGE) ?
                     crbm_pkg::CFG_IMG_W'(crbm_pkg::MAX_IMAGE) : r_icol;
        w_cfg.filt = (r_filt == '0) ? crbm_pkg::CFG_FLT_W'(1) :
                     (32'(r_filt) > crbm_pkg::MAX_FILTERS) ?
                     crbm_pkg::CFG_FLT_W'(crbm_pkg::MAX_FILTERS) : r_filt;
    end

    // Decode the incoming beat
    assign w_take = start && !busy;
    assign w_cmp  = w_take && (i_item.kind == crbm_pkg::KIND_COMPUTE);
    assign w_bad  = (32'(i_item.filter) >= 32'(w_cfg.filt))
                 || (32'(i_item.out_row) + 32'(w_cfg.krow) > 32'(w_cfg.irow))
                 || (32'(i_item.out_col) + 32'(w_cfg.kcol) > 32'(w_cfg.icol));
    assign w_go     = w_cmp && !w_bad;
    assign w_err_go = w_cmp && w_bad;

    // Drop loads that fall outside their store
    assign w_we_wgt  = w_take && (i_item.kind == crbm_pkg::KIND_LOAD_WEIGHT)
                    && (32'(i_item.address) < crbm_pkg::WGT_DEPTH);
    assign w_we_bias = w_take && (i_item.kind == crbm_pkg::KIND_LOAD_BIAS)
                    && (32'(i_item.filter) < crbm_pkg::MAX_FILTERS);
    assign w_we_vis  = w_take && (i_item.kind == crbm_pkg::KIND_LOAD_PIXEL)
                    && (32'(i_item.address) < crbm_pkg::VIS_DEPTH);

    crbm_ram #(
        .WIDTH (crbm_pkg::DATA_W),
        .DEPTH (crbm_pkg::VIS_DEPTH)
    ) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_vis),
        .i_waddr (crbm_pkg::VIS_AW'(i_item.address)),
        .i_wdata (i_item.value),
        .i_re    (w_ctl.rd_en),
        .i_raddr (w_vis_addr),
        .o_rdata (w_vis_q)
    );

    crbm_ram #(
        .WIDTH (crbm_pkg::DATA_W),
        .DEPTH (crbm_pkg::WGT_DEPTH)
    ) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_wgt),
        .i_waddr (crbm_pkg::WGT_AW'(i_item.address)),
        .i_wdata (i_item.value),
        .i_re    (w_ctl.rd_en),
        .i_raddr (w_wgt_addr),
        .o_rdata (w_wgt_q)
    );

    crbm_ram #(
        .WIDTH (crbm_pkg::DATA_W),
        .DEPTH (crbm_pkg::MAX_FILTERS)
    ) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_bias),
        .i_waddr (crbm_pkg::FLT_AW'(i_item.filter)),
        .i_wdata (i_item.value),
        .i_re    (w_ctl.bias_re),
        .i_raddr (w_flt),
        .o_rdata (w_bias_q)
    );

    crbm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_item      (i_item),
        .i_cfg       (w_cfg),
        .i_lgc_valid (w_lgc_valid),
        .o_ctl       (w_ctl),
        .o_tap       (w_tap),
        .o_vis_addr  (w_vis_addr),
        .o_wgt_addr  (w_wgt_addr),
        .o_flt       (w_flt),
        .o_draw      (w_draw)
    );

    crbm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_ctl.clear),
        .i_bias  (w_bias_q),
        .i_tap   (w_tap),
        .i_vis   (w_vis_q),
        .i_wgt   (w_wgt_q),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    crbm_logistic u_logistic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mac_done),
        .i_acc    (w_acc),
        .i_draw   (w_draw),
        .o_valid  (w_lgc_valid),
        .o_result (w_lgc_res)
    );

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_err_go || w_lgc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_err_go) begin
            r_out.probability <= '0;
            r_out.sample      <= 1'b0;
            r_out.status      <= 1'b1;
        end else if (w_lgc_valid) begin
            r_out <= w_lgc_res;
        end
    end

    assign busy     = w_ctl.busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Assertions
    `CRBM_ASSERT_SAME(a_result_idle, o_valid, !busy, "result beat while busy")
    `CRBM_ASSERT_NEXT(a_err_result, w_err_go, o_valid && o_result.status, "missing error beat")
    `CRBM_ASSERT_SAME(a_done_busy, w_mac_done, busy, "accumulator done outside a compute")
    `CRBM_ASSERT_SAME(a_busy_result, $fell(busy) && $past(i_rst_n), o_valid && !o_result.status, "compute ended without result")

endmodule

// ----- test/conv_rbm_hidden_sampler_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv_rbm_hidden_sampler_checker
// Watches the load/compute, register and result channels of the hidden
// sampler. Keeps shadow stores and registers, predicts the logistic
// probability, sample and status of each compute beat, and compares results
// in order.
// ----------------------------------------------------------------------------
module conv_rbm_hidden_sampler_checker
    import crbm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_out_item             i_result,
    input  logic                  i_done,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_CAP = 40;

    // Logistic knots: sigmoid(k/2) scaled to 65536, k = 0..16
    localparam int LOGISTIC_KNOT [0:16] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
        64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };

    // Shadow registers as written
    logic [CFG_CHAN_W-1:0] chan_reg;
    logic [CFG_KRN_W-1:0]  krow_reg;
    logic [CFG_KRN_W-1:0]  kcol_reg;
    logic [CFG_IMG_W-1:0]  irow_reg;
    logic [CFG_IMG_W-1:0]  icol_reg;
    logic [CFG_FLT_W-1:0]  filt_reg;

    // Shadow stores
    logic signed [DATA_W-1:0] pixel_mem  [VIS_DEPTH];
    logic signed [DATA_W-1:0] weight_mem [WGT_DEPTH];
    logic signed [DATA_W-1:0] bias_mem   [MAX_FILTERS];

    t_out_item activation_q [$];
    int        fail_count = 0;
    int        pending_count = 0;
    bit        done_seen = 1'b0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_error(input string what);
        fail_count++;
        if (fail_count <= REPORT_CAP) begin
            $display("[%0t] ERROR: %s", $time, what);
        end
    endtask

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic int used_value(input int raw, input int hi);
        if (raw == 0) begin
            return 1;
        end
        return (raw > hi) ? hi : raw;
    endfunction

    // Piecewise-linear logistic over half-unit segments of |x| (x in Q.24)
    function automatic logic [PROB_W-1:0] logistic_prob(input longint x);
        longint mag;
        longint frac;
        longint slope;
        int     seg;
        int     prob;
        mag = (x < 0) ? -x : x;
        if (mag >= (longint'(8) << 24)) begin
            prob = LOGISTIC_KNOT[16];
        end else begin
            seg   = int'(mag >>> HALF_BITS);
            frac  = mag & ((longint'(1) << HALF_BITS) - 1);
            slope = longint'(LOGISTIC_KNOT[seg + 1] - LOGISTIC_KNOT[seg]);
            prob  = LOGISTIC_KNOT[seg] + int'((slope * frac) >>> HALF_BITS);
        end
        if (x < 0) begin
            prob = 65536 - prob;
        end
        return prob[PROB_W-1:0];
    endfunction

    // Bias plus valid 3-D convolution at one position, then logistic and draw
    function automatic t_out_item predict_activation(input t_in_item beat);
        t_out_item res;
        int        cc, kr, kc, ir, ic, fc;
        int        flt, row, col, pix_idx, wgt_idx;
        longint    acc;
        logic [PROB_W-1:0] prob;
        cc  = used_value(int'(chan_reg), MAX_CHANNELS);
        kr  = used_value(int'(krow_reg), MAX_KERNEL);
        kc  = used_value(int'(kcol_reg), MAX_KERNEL);
        ir  = used_value(int'(irow_reg), MAX_IMAGE);
        ic  = used_value(int'(icol_reg), MAX_IMAGE);
        fc  = used_value(int'(filt_reg), MAX_FILTERS);
        flt = int'(beat.filter);
        row = int'(beat.out_row);
        col = int'(beat.out_col);
        res = '0;
        if (flt >= fc || kr > ir || kc > ic || row > ir - kr || col > ic - kc) begin
            res.status = 1'b1;
            return res;
        end
        acc = longint'(bias_mem[flt]) * (longint'(1) << BIAS_SHIFT);
        for (int ch = 0; ch < cc; ch++) begin
            for (int i = 0; i < kr; i++) begin
                for (int j = 0; j < kc; j++) begin
                    pix_idx = (ch * ir + row + i) * ic + col + j;
                    wgt_idx = ((flt * cc + ch) * kr + i) * kc + j;
                    acc += longint'(pixel_mem[pix_idx]) * longint'(weight_mem[wgt_idx]);
                end
            end
        end
        prob = logistic_prob(acc);
        res.probability = prob;
        res.sample      = (beat.random_draw <= prob);
        return res;
    endfunction

    // Apply one accepted beat: store write or a new expectation
    task automatic take_beat(input t_in_item beat);
        case (beat.kind)
            KIND_LOAD_WEIGHT: begin
                if (int'(beat.address) < WGT_DEPTH) begin
                    weight_mem[beat.address] = beat.value;
                end
            end
            KIND_LOAD_BIAS: begin
                if (int'(beat.filter) < MAX_FILTERS) begin
                    bias_mem[beat.filter] = beat.value;
                end
            end
            KIND_LOAD_PIXEL: begin
                if (int'(beat.address) < VIS_DEPTH) begin
                    pixel_mem[beat.address] = beat.value;
                end
            end
            default: begin
                activation_q.push_back(predict_activation(beat));
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chan_reg = CFG_CHAN_W'(1);
            krow_reg = CFG_KRN_W'(1);
            kcol_reg = CFG_KRN_W'(1);
            irow_reg = CFG_IMG_W'(32);
            icol_reg = CFG_IMG_W'(32);
            filt_reg = CFG_FLT_W'(1);
            activation_q.delete();
        end else begin
            // Compare the result beat with the oldest expectation
            if (i_valid) begin
                if (activation_q.size() == 0) begin
                    report_error($sformatf("unexpected result: prob %0d sample %0b status %0b",
                                           i_result.probability, i_result.sample,
                                           i_result.status));
                end else begin
                    t_out_item want;
                    want = activation_q.pop_front();
                    if (i_result.probability !== want.probability) begin
                        report_error($sformatf("probability %0d, predicted %0d",
                                               i_result.probability, want.probability));
                    end
                    if (i_result.sample !== want.sample) begin
                        report_error($sformatf("sample %0b, predicted %0b",
                                               i_result.sample, want.sample));
                    end
                    if (i_result.status !== want.status) begin
                        report_error($sformatf("status %0b, predicted %0b",
                                               i_result.status, want.status));
                    end
                end
            end
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHANNEL_COUNT: chan_reg = i_cfg_data[CFG_CHAN_W-1:0];
                    CFG_KERNEL_ROWS:   krow_reg = i_cfg_data[CFG_KRN_W-1:0];
                    CFG_KERNEL_COLS:   kcol_reg = i_cfg_data[CFG_KRN_W-1:0];
                    CFG_IMAGE_ROWS:    irow_reg = i_cfg_data[CFG_IMG_W-1:0];
                    CFG_IMAGE_COLS:    icol_reg = i_cfg_data[CFG_IMG_W-1:0];
                    CFG_FILTER_COUNT:  filt_reg = i_cfg_data[CFG_FLT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                take_beat(i_item);
            end
            // Flag results that never came
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (activation_q.size() != 0) begin
                    report_error($sformatf("%0d results never arrived", activation_q.size()));
                end
            end
        end
        pending_count = activation_q.size();
    end

endmodule

// ----- test/tb_conv_rbm_hidden_sampler_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conv_rbm_hidden_sampler_unit
// Fills the stores, runs directed loads and computes over the saturation,
// segment-boundary, ignored-load and invalid-position cases, then random
// load/compute traffic under a series of register settings with random gaps.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_conv_rbm_hidden_sampler_unit;
    import crbm_pkg::*;

    localparam int RANDOM_BEATS  = 1500;
    localparam int PHASES        = 12;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_item              i_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  run_done;
    int                    fail_count;
    int                    pending;

    // Register values in use, for shaping addresses and positions
    int used_chan, used_krow, used_kcol, used_irow, used_icol, used_filt;
    bit steady_phase;
    int unsigned cycle_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    conv_rbm_hidden_sampler_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    conv_rbm_hidden_sampler_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .i_done       (run_done),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int clamp_cfg(input int raw, input int hi);
        if (raw == 0) begin
            return 1;
        end
        return (raw > hi) ? hi : raw;
    endfunction

    function automatic t_in_item make_beat(input logic [1:0] kind, input int addr,
                                           input int value, input int filt,
                                           input int row, input int col, input int draw);
        t_in_item beat;
        beat.kind        = kind;
        beat.address     = addr[11:0];
        beat.value       = value[DATA_W-1:0];
        beat.filter      = filt[2:0];
        beat.out_row     = row[4:0];
        beat.out_col     = col[4:0];
        beat.random_draw = draw[15:0];
        return beat;
    endfunction

    // Mostly small Q4.12 magnitudes so sums land in the logistic slope
    function automatic int rand_value();
        int pick;
        int mag;
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
            case ($urandom_range(0, 3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (pick == 8) begin
            return $urandom_range(0, 16'hFFFF);
        end
        mag = (pick < 6) ? $urandom_range(0, 16'h0400) : $urandom_range(0, 16'h2000);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    function automatic int rand_gap();
        int pick;
        if (steady_phase) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end
        if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Loads aimed mostly at the part of each store the settings use
    function automatic t_in_item rand_load();
        int pick;
        int span;
        int addr;
        int filt;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            span = used_filt * used_chan * used_krow * used_kcol;
            addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, span - 1);
            return make_beat(KIND_LOAD_WEIGHT, addr, rand_value(), $urandom_range(0, 7),
                             $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 16'hFFFF));
        end
        if (pick < 7) begin
            filt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                               : $urandom_range(0, used_filt - 1);
            return make_beat(KIND_LOAD_BIAS, $urandom_range(0, 4095), rand_value(), filt,
                             $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 16'hFFFF));
        end
        span = used_chan * used_irow * used_icol;
        addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                           : $urandom_range(0, span - 1);
        return make_beat(KIND_LOAD_PIXEL, addr, rand_value(), $urandom_range(0, 7),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 16'hFFFF));
    endfunction

    // Computes mostly at valid positions, the rest anywhere
    function automatic t_in_item rand_compute();
        int filt, row, col, draw;
        filt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                           : $urandom_range(0, used_filt - 1);
        if (used_irow >= used_krow && $urandom_range(0, 7) != 0) begin
            row = $urandom_range(0, used_irow - used_krow);
        end else begin
            row = $urandom_range(0, 31);
        end
        if (used_icol >= used_kcol && $urandom_range(0, 7) != 0) begin
            col = $urandom_range(0, used_icol - used_kcol);
        end else begin
            col = $urandom_range(0, 31);
        end
        case ($urandom_range(0, 9))
            0:       draw = 0;
            1:       draw = 16'hFFFF;
            default: draw = $urandom_range(0, 16'hFFFF);
        endcase
        return make_beat(KIND_COMPUTE, $urandom_range(0, 4095), rand_value(), filt,
                         row, col, draw);
    endfunction

    // Hold the beat until taken; start stays high when no gap follows
    task automatic put_beat(input t_in_item beat, input int gap);
        start  <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start, wait for every pending result, then let loads settle
    task automatic drain_results();
        int waited;
        start  <= 1'b0;
        waited = 0;
        @(negedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
    endtask

    // Write all six registers back to back; call only while idle
    task automatic apply_settings(input int chan, input int krow, input int kcol,
                                  input int irow, input int icol, input int filt);
        cfg_write(CFG_CHANNEL_COUNT, chan);
        cfg_write(CFG_KERNEL_ROWS, krow);
        cfg_write(CFG_KERNEL_COLS, kcol);
        cfg_write(CFG_IMAGE_ROWS, irow);
        cfg_write(CFG_IMAGE_COLS, icol);
        cfg_write(CFG_FILTER_COUNT, filt);
        i_cfg_we  <= 1'b0;
        used_chan = clamp_cfg(chan & ((1 << CFG_CHAN_W) - 1), MAX_CHANNELS);
        used_krow = clamp_cfg(krow & ((1 << CFG_KRN_W) - 1), MAX_KERNEL);
        used_kcol = clamp_cfg(kcol & ((1 << CFG_KRN_W) - 1), MAX_KERNEL);
        used_irow = clamp_cfg(irow & ((1 << CFG_IMG_W) - 1), MAX_IMAGE);
        used_icol = clamp_cfg(icol & ((1 << CFG_IMG_W) - 1), MAX_IMAGE);
        used_filt = clamp_cfg(filt & ((1 << CFG_FLT_W) - 1), MAX_FILTERS);
    endtask

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int beats_per_phase;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        run_done   <= 1'b0;
        used_chan  = 1;
        used_krow  = 1;
        used_kcol  = 1;
        used_irow  = 32;
        used_icol  = 32;
        used_filt  = 1;
        steady_phase = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every store entry so no compute reads unwritten data
        for (int a = 0; a < VIS_DEPTH; a++) begin
            put_beat(make_beat(KIND_LOAD_PIXEL, a, rand_value(), 0, 0, 0, 0), 0);
        end
        for (int a = 0; a < WGT_DEPTH; a++) begin
            put_beat(make_beat(KIND_LOAD_WEIGHT, a, rand_value(), 0, 0, 0, 0), 0);
        end
        for (int f = 0; f < MAX_FILTERS; f++) begin
            put_beat(make_beat(KIND_LOAD_BIAS, 0, rand_value(), f, 0, 0, 0), 0);
        end

        // Directed: reset settings, one-tap kernel on a 32x32 image
        // saturate high, then low
        put_beat(make_beat(KIND_LOAD_BIAS, 0, 0, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_LOAD_WEIGHT, 0, 16'h7FFF, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_LOAD_PIXEL, 0, 16'h7FFF, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 0, 0, 0), 1);
        put_beat(make_beat(KIND_LOAD_PIXEL, 0, 16'h8000, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 0, 0, 16'hFFFF), 0);
        // x = +0.5 sits on a segment boundary; draw equal to and one above it
        put_beat(make_beat(KIND_LOAD_WEIGHT, 0, 16'h1000, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_LOAD_PIXEL, 1023, 16'h0800, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 31, 31, 40793), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 31, 31, 40794), 2);
        // weight loads beyond the store are dropped
        put_beat(make_beat(KIND_LOAD_WEIGHT, WGT_DEPTH, 16'h7FFF, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_LOAD_WEIGHT, 4095, 16'h8000, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 31, 31, 0), 0);
        // negative bias alone, then zero input
        put_beat(make_beat(KIND_LOAD_BIAS, 0, 16'hF800, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_LOAD_PIXEL, 1023, 0, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 31, 31, 24743), 0);
        put_beat(make_beat(KIND_LOAD_BIAS, 0, 0, 0, 0, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 31, 31, 32768), 0);
        // filter beyond the configured count
        put_beat(make_beat(KIND_LOAD_BIAS, 0, 16'h7FFF, 7, 0, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 7, 0, 0, 0), 0);
        drain_results();

        // Position past the image edge on either axis
        apply_settings(1, 1, 1, 4, 4, 1);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 3, 3, 16'h8000), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 4, 0, 0), 0);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 0, 4, 0), 0);
        drain_results();

        // Kernel taller than the image
        apply_settings(1, 8, 1, 4, 4, 1);
        put_beat(make_beat(KIND_COMPUTE, 0, 0, 0, 0, 0, 0), 0);
        drain_results();

        // Random traffic over a series of settings
        beats_per_phase = RANDOM_BEATS / PHASES;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       apply_settings(1, 1, 1, 32, 32, 1);
                1:       apply_settings(4, 8, 8, 32, 32, 8);
                2:       apply_settings(1, 1, 1, 1, 1, 1);
                3:       apply_settings(63, 63, 63, 63, 63, 63);
                4:       apply_settings(0, 0, 0, 0, 0, 0);
                5:       apply_settings(3, 2, 8, 32, 4, 2);
                default: begin
                    apply_settings($urandom_range(0, 63),
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(1, 3),
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(1, 3),
                                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                               : $urandom_range(1, 12),
                                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                               : $urandom_range(1, 12),
                                   $urandom_range(0, 63));
                end
            endcase
            steady_phase = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < beats_per_phase; n++) begin
                if ($urandom_range(0, 9) < 4) begin
                    put_beat(rand_compute(), rand_gap());
                end else begin
                    put_beat(rand_load(), rand_gap());
                end
            end
            drain_results();
        end

        // Let the checker flag anything left over, then give the verdict
        run_done <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
